// ===== hw/rtl/e2q_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// e2q_pkg
// Types and constants shared by the Euler-angle to quaternion pipeline.
// ----------------------------------------------------------------------------
package e2q_pkg;

    localparam int ANGLE_W = 16;
    localparam int QUAT_W  = 16;

    // one input word: three angles, Q2.13 radians
    typedef struct packed {
        logic signed [ANGLE_W-1:0] roll_angle;
        logic signed [ANGLE_W-1:0] pitch_angle;
        logic signed [ANGLE_W-1:0] yaw_angle;
    } t_angles;

    // one output word: quaternion components, Q1.14
    typedef struct packed {
        logic signed [QUAT_W-1:0] quat_w;
        logic signed [QUAT_W-1:0] quat_x;
        logic signed [QUAT_W-1:0] quat_y;
        logic signed [QUAT_W-1:0] quat_z;
    } t_quat;

    localparam logic signed [35:0] Q30_PI      = 36'sd3373259426;
    localparam logic signed [35:0] Q30_HALF_PI = 36'sd1686629713;
    localparam logic signed [35:0] Q30_GAIN    = 36'sd652032874;
    localparam logic signed [47:0] OUT_MAX     = 48'sd16384;

    // atan(2^-i) in Q.30
    function automatic logic signed [35:0] atan_q30(input logic [4:0] i);
        logic signed [35:0] r;
        unique case (i)
            5'd0: r = 36'sd843314857;
            5'd1: r = 36'sd497837829;
            5'd2: r = 36'sd263043837;
            5'd3: r = 36'sd133525159;
            5'd4: r = 36'sd67021687;
            5'd5: r = 36'sd33543516;
            5'd6: r = 36'sd16775851;
            5'd7: r = 36'sd8388437;
            5'd8: r = 36'sd4194283;
            5'd9: r = 36'sd2097149;
            default: r = 36'sd1 <<< (5'd30 - i);
        endcase
        if (i == 5'd31) begin
            r = '0;
        end
        return r;
    endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/euler_to_quaternion.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// euler_to_quaternion
// ZYX Euler angles to unit quaternion: pipelined CORDIC and product tree.
// ----------------------------------------------------------------------------
// Fully pipelined: one word in and one word out every cycle while not
// stalled. Stages: one fold stage, one register per CORDIC iteration, one
// rounding stage, two product stages, one sum stage and one saturation
// stage. A stall freezes the whole pipeline; the output register may still
// take a new word while its held word is consumed.
module euler_to_quaternion #(
    parameter int CORDIC_STAGES = 16
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_valid,
    output logic                 o_ready,
    input  wire e2q_pkg::t_angles i_data,
    output logic                 o_valid,
    input  wire                  i_ready,
    output e2q_pkg::t_quat       o_data
);
    import e2q_pkg::*;

    localparam int NS = CORDIC_STAGES + 6;

    logic                  adv;
    logic [NS-1:0]         r_vld;

    // pipeline moves when the last stage is empty or drained
    assign adv     = !r_vld[NS-1] || i_ready;
    assign o_ready = adv;
    assign o_valid = r_vld[NS-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (adv) begin
            r_vld <= {r_vld[NS-2:0], i_valid};
        end
    end

    // ---------------- fold: half angle in Q.30 ----------------
    logic signed [35:0] half [3];
    logic signed [35:0] r_z0 [3];
    logic               r_neg0 [3];
    logic [ANGLE_W-1:0] raw [3];

    assign raw[0] = i_data.roll_angle[ANGLE_W-1:0];
    assign raw[1] = i_data.pitch_angle[ANGLE_W-1:0];
    assign raw[2] = i_data.yaw_angle[ANGLE_W-1:0];

    always_comb begin
        for (int a = 0; a < 3; a++) begin
            half[a] = 36'(signed'(raw[a])) <<< (32 - ANGLE_W);
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            for (int a = 0; a < 3; a++) begin
                if (half[a] > Q30_HALF_PI) begin
                    r_z0[a]   <= half[a] - Q30_PI;
                    r_neg0[a] <= 1'b1;
                end else if (half[a] < -Q30_HALF_PI) begin
                    r_z0[a]   <= half[a] + Q30_PI;
                    r_neg0[a] <= 1'b1;
                end else begin
                    r_z0[a]   <= half[a];
                    r_neg0[a] <= 1'b0;
                end
            end
        end
    end

    // ---------------- cordic stages ----------------
    logic signed [35:0] r_cx [CORDIC_STAGES+1][3];
    logic signed [35:0] r_cy [CORDIC_STAGES+1][3];
    logic signed [35:0] r_cz [CORDIC_STAGES+1][3];
    logic               r_cn [CORDIC_STAGES+1][3];

    always_comb begin
        for (int a = 0; a < 3; a++) begin
            r_cx[0][a] = Q30_GAIN;
            r_cy[0][a] = '0;
            r_cz[0][a] = r_z0[a];
            r_cn[0][a] = r_neg0[a];
        end
    end

    for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_cordic
        localparam logic [4:0] SH = 5'(g);
        always_ff @(posedge i_clk) begin
            if (adv) begin
                for (int a = 0; a < 3; a++) begin
                    r_cn[g+1][a] <= r_cn[g][a];
                    if (r_cz[g][a] >= 0) begin
                        r_cx[g+1][a] <= r_cx[g][a] - (r_cy[g][a] >>> SH);
                        r_cy[g+1][a] <= r_cy[g][a] + (r_cx[g][a] >>> SH);
                        r_cz[g+1][a] <= r_cz[g][a] - atan_q30(SH);
                    end else begin
                        r_cx[g+1][a] <= r_cx[g][a] + (r_cy[g][a] >>> SH);
                        r_cy[g+1][a] <= r_cy[g][a] - (r_cx[g][a] >>> SH);
                        r_cz[g+1][a] <= r_cz[g][a] + atan_q30(SH);
                    end
                end
            end
        end
    end

    // ---------------- negate and round to Q.24 ----------------
    logic signed [29:0] r_s [3];
    logic signed [29:0] r_c [3];
    logic signed [35:0] fx [3];
    logic signed [35:0] fy [3];

    always_comb begin
        for (int a = 0; a < 3; a++) begin
            fx[a] = r_cn[CORDIC_STAGES][a] ? -r_cx[CORDIC_STAGES][a]
                                           :  r_cx[CORDIC_STAGES][a];
            fy[a] = r_cn[CORDIC_STAGES][a] ? -r_cy[CORDIC_STAGES][a]
                                           :  r_cy[CORDIC_STAGES][a];
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            for (int a = 0; a < 3; a++) begin
                r_c[a] <= 30'((fx[a] + 36'sd32) >>> 6);
                r_s[a] <= 30'((fy[a] + 36'sd32) >>> 6);
            end
        end
    end

    // ---------------- pair products, rounded to Q.24 ----------------
    // pairs: cr*cp, sr*sp, sr*cp, cr*sp
    logic signed [59:0] r_pp [4];
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_pp[0] <= 60'(r_c[0]) * 60'(r_c[1]);
            r_pp[1] <= 60'(r_s[0]) * 60'(r_s[1]);
            r_pp[2] <= 60'(r_s[0]) * 60'(r_c[1]);
            r_pp[3] <= 60'(r_c[0]) * 60'(r_s[1]);
        end
    end

    logic signed [29:0] r_sy1, r_cy1;
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_sy1 <= r_s[2];
            r_cy1 <= r_c[2];
        end
    end

    logic signed [35:0] pr [4];
    always_comb begin
        for (int k = 0; k < 4; k++) begin
            pr[k] = 36'((r_pp[k] + (60'sd1 <<< 23)) >>> 24);
        end
    end

    // third factor: eight products
    logic signed [63:0] r_t [8];
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_t[0] <= 64'(pr[0]) * 64'(r_cy1);
            r_t[1] <= 64'(pr[1]) * 64'(r_sy1);
            r_t[2] <= 64'(pr[2]) * 64'(r_cy1);
            r_t[3] <= 64'(pr[3]) * 64'(r_sy1);
            r_t[4] <= 64'(pr[3]) * 64'(r_cy1);
            r_t[5] <= 64'(pr[2]) * 64'(r_sy1);
            r_t[6] <= 64'(pr[0]) * 64'(r_sy1);
            r_t[7] <= 64'(pr[1]) * 64'(r_cy1);
        end
    end

    // ---------------- sums ----------------
    logic signed [64:0] r_sum [4];
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_sum[0] <= 65'(r_t[0]) + 65'(r_t[1]);
            r_sum[1] <= 65'(r_t[2]) - 65'(r_t[3]);
            r_sum[2] <= 65'(r_t[4]) + 65'(r_t[5]);
            r_sum[3] <= 65'(r_t[6]) - 65'(r_t[7]);
        end
    end

    // ---------------- round to Q1.14 and saturate ----------------
    logic signed [30:0] rnd [4];
    logic signed [15:0] sat [4];
    always_comb begin
        for (int k = 0; k < 4; k++) begin
            rnd[k] = 31'((r_sum[k] + (65'sd1 <<< 33)) >>> 34);
            if (rnd[k] > 31'sd16384) begin
                sat[k] = 16'sd16384;
            end else if (rnd[k] < -31'sd16384) begin
                sat[k] = -16'sd16384;
            end else begin
                sat[k] = 16'(rnd[k]);
            end
        end
    end

    t_quat r_out;
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out.quat_w <= sat[0];
            r_out.quat_x <= sat[1];
            r_out.quat_y <= sat[2];
            r_out.quat_z <= sat[3];
        end
    end
    assign o_data = r_out;

    // unused sensor of the cordic residual angle and of OUT_MAX
    logic unused_z;
    assign unused_z = ^r_cz[CORDIC_STAGES][0] ^ ^r_cz[CORDIC_STAGES][1]
                    ^ ^r_cz[CORDIC_STAGES][2] ^ ^OUT_MAX;

`ifndef SYNTHESIS
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_data))
        else $error("output word changed while stalled");
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> o_ready)
        else $error("pipeline stalled with empty output");
    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_data.quat_w <= 16'sd16384 && o_data.quat_w >= -16'sd16384))
        else $error("quat_w out of range");
    a_freeze: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_ready |=> $stable(r_vld))
        else $error("valid bits moved during stall");
`endif

endmodule
`default_nettype wire

// ===== dv/e2q_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// e2q_checker
// Watches both channels of the Euler-to-quaternion block, predicts every
// output word from the accepted angles and compares the words in order.
// ----------------------------------------------------------------------------
module e2q_checker (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_in_valid,
    input  wire                  i_in_ready,
    input  e2q_pkg::t_angles     i_in_data,
    input  wire                  i_out_valid,
    input  wire                  i_out_ready,
    input  e2q_pkg::t_quat       i_out_data,
    output int                   o_errors,
    output int                   o_pending
);
    import e2q_pkg::*;

    localparam longint PI_Q30   = 64'sd3373259426;
    localparam longint HPI_Q30  = 64'sd1686629713;
    localparam longint GAIN_Q30 = 64'sd652032874;
    localparam longint QMAX     = 64'sd16384;
    localparam int     STAGES   = 16;

    t_quat quat_q[$];

    function automatic longint arctan_q30(int i);
        longint tbl[10] = '{843314857, 497837829, 263043837, 133525159, 67021687,
                            33543516, 16775851, 8388437, 4194283, 2097149};
        if (i < 10) begin
            return tbl[i];
        end
        if (i <= 30) begin
            return longint'(1) << (30 - i);
        end
        return 0;
    endfunction

    function automatic longint rnd_shr(longint v, int s);
        return (v + (longint'(1) << (s - 1))) >>> s;
    endfunction

    // sine and cosine of the half angle, Q.24
    function automatic void half_sincos(input logic signed [15:0] ang,
                                        output longint s, output longint c);
        longint z, x, y, dx, dy;
        bit flip;
        z = longint'(ang) <<< 16;
        x = GAIN_Q30;
        y = 0;
        flip = 0;
        if (z > HPI_Q30) begin
            z = z - PI_Q30;
            flip = 1;
        end else if (z < -HPI_Q30) begin
            z = z + PI_Q30;
            flip = 1;
        end
        for (int i = 0; i < STAGES; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                x -= dx; y += dy; z -= arctan_q30(i);
            end else begin
                x += dx; y -= dy; z += arctan_q30(i);
            end
        end
        if (flip) begin
            x = -x;
            y = -y;
        end
        c = rnd_shr(x, 6);
        s = rnd_shr(y, 6);
    endfunction

    function automatic longint triple(longint a, longint b, longint c);
        return rnd_shr(a * b, 24) * c;
    endfunction

    function automatic logic signed [15:0] to_q14(longint v);
        longint r;
        r = rnd_shr(v, 34);
        if (r > QMAX) r = QMAX;
        if (r < -QMAX) r = -QMAX;
        return r[15:0];
    endfunction

    function automatic t_quat quat_of(t_angles a);
        longint sr, cr, sp, cp, sy, cy;
        t_quat q;
        half_sincos(a.roll_angle, sr, cr);
        half_sincos(a.pitch_angle, sp, cp);
        half_sincos(a.yaw_angle, sy, cy);
        q.quat_w = to_q14(triple(cr, cp, cy) + triple(sr, sp, sy));
        q.quat_x = to_q14(triple(sr, cp, cy) - triple(cr, sp, sy));
        q.quat_y = to_q14(triple(cr, sp, cy) + triple(sr, cp, sy));
        q.quat_z = to_q14(triple(cr, cp, sy) - triple(sr, sp, cy));
        return q;
    endfunction

    always @(posedge i_clk) begin
        t_quat want;
        if (i_rst_n) begin
            if (i_in_valid && i_in_ready) begin
                quat_q.push_back(quat_of(i_in_data));
            end
            if (i_out_valid && i_out_ready) begin
                if (quat_q.size() == 0) begin
                    $error("unexpected word %h", i_out_data);
                    o_errors <= o_errors + 1;
                end else begin
                    want = quat_q.pop_front();
                    if (want != i_out_data) begin
                        o_errors <= o_errors + 1;
                        if (want.quat_w != i_out_data.quat_w)
                            $error("quat_w exp %0d got %0d", want.quat_w, i_out_data.quat_w);
                        if (want.quat_x != i_out_data.quat_x)
                            $error("quat_x exp %0d got %0d", want.quat_x, i_out_data.quat_x);
                        if (want.quat_y != i_out_data.quat_y)
                            $error("quat_y exp %0d got %0d", want.quat_y, i_out_data.quat_y);
                        if (want.quat_z != i_out_data.quat_z)
                            $error("quat_z exp %0d got %0d", want.quat_z, i_out_data.quat_z);
                    end
                end
            end
        end
        o_pending <= quat_q.size();
    end
endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Drives angle words into the Euler-to-quaternion block under random idling
// and reports the verdict from the checker.
// ----------------------------------------------------------------------------
module tb_top;
    import e2q_pkg::*;

    localparam int LATENCY   = 22;
    localparam int CYCLE_CAP = 200000;
    localparam logic [15:0] EDGES [8] = '{16'h0000, 16'h7fff, 16'h8000, 16'hffff,
                                          16'h0001, 16'h6488, 16'h9b78, 16'h3244};

    logic     clk = 0;
    logic     rst_n = 0;
    logic     in_valid = 0;
    logic     in_ready;
    t_angles  in_data = '0;
    logic     out_valid;
    logic     out_ready = 0;
    t_quat    out_data;
    int       errors;
    int       pending;
    int       cycles = 0;
    int       send_idle_pct = 19;
    int       recv_idle_pct = 48;

    always #10 clk = ~clk;

    euler_to_quaternion u_dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_valid (in_valid),
        .o_ready (in_ready),
        .i_data  (in_data),
        .o_valid (out_valid),
        .i_ready (out_ready),
        .o_data  (out_data)
    );

    e2q_checker u_chk (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .i_in_ready  (in_ready),
        .i_in_data   (in_data),
        .i_out_valid (out_valid),
        .i_out_ready (out_ready),
        .i_out_data  (out_data),
        .o_errors    (errors),
        .o_pending   (pending)
    );

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_CAP) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    always @(negedge clk) begin
        out_ready <= rst_n && ($urandom_range(99) >= recv_idle_pct);
    end

    function automatic logic [15:0] rand_angle();
        case ($urandom_range(5))
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return 16'($urandom_range(0, 8) - 4);
            // near the quadrant fold, +/- pi in Q2.13 is about 25736
            3: return 16'($urandom_range(25700, 25770));
            4: return 16'(-$urandom_range(25700, 25770));
            default: return 16'($urandom);
        endcase
    endfunction

    // one word, with a random idle gap before it; valid stays high on return
    task automatic send_word(input t_angles a);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 0;
            @(negedge clk);
        end
        in_valid <= 1;
        in_data  <= a;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        @(negedge clk);
    endtask

    initial begin
        t_angles a;
        repeat (6) @(negedge clk);
        rst_n <= 1;
        @(negedge clk);
        // corner angles on each axis, then all together
        for (int i = 0; i < 8; i++) begin
            send_word('{EDGES[i], 16'h0, 16'h0});
            send_word('{16'h0, EDGES[i], 16'h0});
            send_word('{16'h0, 16'h0, EDGES[i]});
        end
        send_word('{EDGES[1], EDGES[2], EDGES[3]});
        // let the pipe drain once before the random words
        in_valid <= 0;
        while (pending != 0) @(negedge clk);
        for (int phase = 0; phase < 3; phase++) begin
            send_idle_pct = (phase == 0) ? 19 : (phase == 1) ? 48 : 0;
            recv_idle_pct = (phase == 0) ? 48 : (phase == 1) ? 19 : 0;
            for (int n = 0; n < 670; n++) begin
                a.roll_angle  = rand_angle();
                a.pitch_angle = rand_angle();
                a.yaw_angle   = rand_angle();
                send_word(a);
            end
        end
        in_valid <= 0;
        while (pending != 0) @(negedge clk);
        repeat (LATENCY + 5) @(negedge clk);
        if (errors == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end
endmodule
